>>> rtl/sstif_pkg.sv
// Package for the seismic sample to IEEE single converter.
// Holds format codes, register indexes and the leading-one helper function.
// Depends on nothing.
package sstif_pkg;

	localparam int unsigned WordW = 32;
	localparam int unsigned FmtW  = 3;
	localparam int unsigned CfgIdxW = 1;

	typedef enum logic [FmtW-1:0] {
		FMT_IBM   = 3'd1,
		FMT_INT32 = 3'd2,
		FMT_INT16 = 3'd3,
		FMT_IEEE  = 3'd5
	} fmt_t;

	localparam logic [CfgIdxW-1:0] REG_FORMAT = 1'b0;
	localparam logic [CfgIdxW-1:0] REG_SWAP   = 1'b1;

	localparam logic [FmtW-1:0] FormatReset = 3'd1;

	// Position of the leading one of a 32-bit word (0 when the word is zero).
	function automatic logic [4:0] lead_pos(input logic [31:0] v);
		logic [4:0] p;
		p = 5'd0;
		for (int i = 0; i < 32; i++) begin
			if (v[i]) begin
				p = 5'(i);
			end
		end
		return p;
	endfunction

endpackage

>>> rtl/seismic_sample_to_ieee_float.sv
// Top level of the seismic trace sample to IEEE single converter.
// Depends on sstif_pkg and sstif_conv.
//
// Channel   Signals                                      Beat
// input     in_valid, in_stall, raw_sample               one raw sample word
// output    out_valid, out_stall, ieee_bits, format_error  one converted sample
// config    cfg_valid, cfg_ready, cfg_index, cfg_data    one register write
//
// Each accepted beat sits in the input register while the conversion logic works
// on it, and is then loaded into the result register.
// One beat is accepted every cycle while the output is not stalled; the input
// stalls only when both registers are full and the result is held.
// Reset (arst_n low) clears both valid flags and loads format 1, no swap.
// A stall holds the result register and, through in_stall, the input register.
module seismic_sample_to_ieee_float
	import sstif_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [WordW-1:0]    raw_sample,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [WordW-1:0]    ieee_bits,
	output logic                format_error,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [WordW-1:0]    cfg_data
);

	logic [FmtW-1:0]  fmt_q;
	logic             swap_q;
	logic             v_s1;
	logic [WordW-1:0] raw_s1;
	logic [WordW-1:0] bits_c;
	logic             err_c;
	logic             adv2;
	logic             adv1;

	// The result stage moves whenever it is free; the input stage also moves whenever it is empty.
	assign adv2      = !out_valid || !out_stall;
	assign adv1      = !v_s1 || adv2;
	assign in_stall  = !adv1;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q  <= FormatReset;
			swap_q <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_FORMAT: fmt_q  <= cfg_data[FmtW-1:0];
				REG_SWAP:   swap_q <= cfg_data[0];
				default:    ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (adv1) begin
				v_s1 <= in_valid;
			end
			if (adv2) begin
				out_valid <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && in_valid) begin
			raw_s1 <= raw_sample;
		end
		if (adv2 && v_s1) begin
			ieee_bits    <= bits_c;
			format_error <= err_c;
		end
	end

	sstif_conv u_conv (
		.fmt  (fmt_q),
		.swap (swap_q),
		.word (raw_s1),
		.bits (bits_c),
		.err  (err_c)
	);

	// A stalled result must not be overwritten by the stage behind it.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(ieee_bits))
		else $error("result changed under stall");

	// The input side stalls only when both stages are full and blocked.
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> v_s1 && out_valid && out_stall)
		else $error("needless input stall");

	// An error result is always a zero word.
	a_err: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && format_error |-> ieee_bits == '0)
		else $error("error result not zero");

endmodule

>>> rtl/sstif_conv.sv
// Combinational conversion of one aligned sample word to IEEE single.
// Uses sstif_pkg for format codes and the leading-one helper.
module sstif_conv
	import sstif_pkg::*;
(
	input  logic [FmtW-1:0]  fmt,
	input  logic             swap,
	input  logic [WordW-1:0] word,
	output logic [WordW-1:0] bits,
	output logic             err
);

	logic [31:0] w32, w16, w;
	logic [23:0] frac, nfrac;
	logic [4:0]  ibm_lz;
	logic [9:0]  bexp;
	logic [31:0] ibm_res;
	logic        neg;
	logic [31:0] mag;
	logic [4:0]  top;
	logic [4:0]  sh;
	logic [31:0] keep0, rem, half;
	logic [24:0] keep;
	logic        rup;
	logic [7:0]  iexp;
	logic [31:0] int_res;

	assign w32 = swap ? {word[7:0], word[15:8], word[23:16], word[31:24]} : word;
	assign w16 = swap ? {16'd0, word[7:0], word[15:8]} : {16'd0, word[15:0]};

	// IBM hex float: normalise the 24-bit fraction with one leading-one search.
	assign frac   = w32[23:0];
	assign ibm_lz = 5'd23 - lead_pos({8'd0, frac});
	assign nfrac  = frac << ibm_lz;
	assign bexp   = {1'b0, w32[30:24], 2'b00} - 10'd256 - {5'd0, ibm_lz} + 10'd126;
	assign ibm_res = (frac == 24'd0) ? 32'd0 :
		{w32[31], bexp[9:8] != 2'b00 ? 8'd0 : bexp[7:0], nfrac[22:0]};

	// Integers: sign and magnitude, then round to nearest even.
	assign w   = (fmt == FMT_INT16) ? {{16{w16[15]}}, w16[15:0]} : w32;
	assign neg = w[31];
	assign mag = neg ? (~w + 32'd1) : w;
	assign top = lead_pos(mag);
	assign sh  = (top > 5'd23) ? top - 5'd23 : 5'd0;
	assign keep0 = (top > 5'd23) ? (mag >> sh) : (mag << (5'd23 - top));
	assign rem  = mag & ((32'd1 << sh) - 32'd1);
	assign half = (sh == 5'd0) ? 32'd0 : (32'd1 << (sh - 5'd1));
	assign rup  = (sh != 5'd0) && ((rem > half) || (rem == half && keep0[0]));
	assign keep = {1'b0, keep0[23:0]} + {24'd0, rup};
	assign iexp = 8'd127 + {3'd0, top} + {7'd0, keep[24]};
	assign int_res = (mag == 32'd0) ? 32'd0 :
		{neg, iexp, keep[24] ? keep[23:1] : keep[22:0]};

	always_comb begin
		bits = 32'd0;
		err  = 1'b0;
		case (fmt)
			FMT_IBM:   bits = ibm_res;
			FMT_INT32: bits = int_res;
			FMT_INT16: bits = int_res;
			FMT_IEEE:  bits = w32;
			default:   err = 1'b1;
		endcase
	end

endmodule
